// ===== rtl/core/skt_pkg.sv =====
// Shared constants and controller/datapath interface types for the sorted key table.
package skt_pkg;

  // Default geometry.
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int KEY_CHARS_DEF   = 8;

  // Fixed port widths.
  localparam int SLOT_W     = 8;
  localparam int COUNT_W    = 9;
  localparam int KEY_PORT_W = 64;
  localparam int IDX_W      = 8;

  // Request type codes.
  localparam logic REQ_SEARCH = 1'b1;

  // Controller -> datapath commands.
  typedef struct packed {
    logic write;     // store entry_key at slot
    logic start;     // latch search key, init bounds
    logic rd;        // issue a table read at the next probe address
    logic step;      // narrow the bounds from the current compare
    logic hit;       // capture the matching entry
    logic load_out;  // move the search result into the output register
  } cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic range_ok;  // low < high on the registered bounds
    logic eq;        // probed entry equals the key
    logic next_ok;   // low < high after this step
  } status_t;

endpackage

// ===== rtl/core/sorted_key_table_binary_search.sv =====
// Top level of the sorted key table with binary search lookup.
//
// Holds TABLE_DEPTH keys of 8*KEY_CHARS bits (packed big-endian strings)
// and answers lookups by half-open binary search over slots
// 0..entry_count-1 (entry_count saturates at TABLE_DEPTH). A write
// transfer (req_type 0) stores entry_key at slot and gives no result;
// slots at or above TABLE_DEPTH are dropped. A search transfer
// (req_type 1) makes P probes before its result is loaded, where P is at
// most ceil(log2(entry_count + 1)): 9 probes for a full 256-entry table.
// Each probe is one read of the table RAM, whose registered read port
// sets the pace; the next probe address is formed in the same cycle as
// the compare. The input side takes one transfer at a time but does
// accept new transfers while a result waits in the output register. A
// miss reports found, match_index and match_key all zero. Keys above
// 8*KEY_CHARS bits are ignored. The table has no reset; every probed
// slot must have been written first. The user must write entry_count
// via cfg_wen/cfg_wdata only while idle; the block does not enforce it.
module sorted_key_table_binary_search #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_CHARS   = skt_pkg::KEY_CHARS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wen,
  input  logic [skt_pkg::COUNT_W-1:0]    cfg_wdata,
  // request channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           req_type,
  input  logic [skt_pkg::SLOT_W-1:0]     slot,
  input  logic [skt_pkg::KEY_PORT_W-1:0] entry_key,
  input  logic [skt_pkg::KEY_PORT_W-1:0] search_key,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           found,
  output logic [skt_pkg::IDX_W-1:0]      match_index,
  output logic [skt_pkg::KEY_PORT_W-1:0] match_key
);

  logic [skt_pkg::COUNT_W-1:0] entry_count;
  skt_pkg::cmd_t               cmd;
  skt_pkg::status_t            status;

  // Number of live entries; reset clears the count, so the table reads as empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_wen) begin
      entry_count <= cfg_wdata;
    end
  end

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .req_type (req_type),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  skt_dp #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .KEY_CHARS  (KEY_CHARS)
  ) u_dp (
    .clk        (clk),
    .cmd        (cmd),
    .entry_count(entry_count),
    .slot       (slot),
    .entry_key  (entry_key),
    .search_key (search_key),
    .status     (status),
    .found      (found),
    .match_index(match_index),
    .match_key  (match_key)
  );

  // A miss carries an all-zero payload.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> match_index == '0 && match_key == '0)
    else $error("miss result with nonzero payload");

  // A hit always lies inside the searched range.
  a_hit_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> {1'b0, match_index} < entry_count)
    else $error("hit index outside entry range");

  // A search transfer occupies the input side on the following cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == skt_pkg::REQ_SEARCH |=> in_stall)
    else $error("input accepted during a search");

endmodule

// ===== rtl/core/skt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/skt_dp.sv =====
// Search datapath: key table, bound registers, probe compare and result register.
module skt_dp #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEF,
  parameter int KEY_CHARS   = skt_pkg::KEY_CHARS_DEF
) (
  input  logic                              clk,
  input  skt_pkg::cmd_t                     cmd,
  input  logic [skt_pkg::COUNT_W-1:0]       entry_count,
  input  logic [skt_pkg::SLOT_W-1:0]        slot,
  input  logic [skt_pkg::KEY_PORT_W-1:0]    entry_key,
  input  logic [skt_pkg::KEY_PORT_W-1:0]    search_key,
  output skt_pkg::status_t                  status,
  output logic                              found,
  output logic [skt_pkg::IDX_W-1:0]         match_index,
  output logic [skt_pkg::KEY_PORT_W-1:0]    match_key
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int PTR_W  = ADDR_W + 1;
  localparam int CW     = (PTR_W > skt_pkg::COUNT_W) ? PTR_W : skt_pkg::COUNT_W;
  localparam int KEY_W  = 8 * KEY_CHARS;
  localparam int KP_W   = skt_pkg::KEY_PORT_W;
  localparam int IX_W   = skt_pkg::IDX_W;

  logic [KEY_W-1:0]  key;
  logic [KEY_W-1:0]  hit_key;
  logic [KEY_W-1:0]  rd_data;
  logic [PTR_W-1:0]  lo;
  logic [PTR_W-1:0]  hi;
  logic [PTR_W-1:0]  lo_next;
  logic [PTR_W-1:0]  hi_next;
  logic [PTR_W-1:0]  hmax;
  logic [PTR_W:0]    sum_c;
  logic [PTR_W:0]    sum_n;
  logic [ADDR_W-1:0] mid;
  logic [ADDR_W-1:0] mid_c;
  logic [ADDR_W-1:0] mid_n;
  logic [ADDR_W-1:0] rd_addr;
  logic              hit;
  logic              lt;
  logic              slot_ok;

  // Count saturates at the table depth.
  assign hmax = (CW'(entry_count) > CW'(TABLE_DEPTH)) ? PTR_W'(TABLE_DEPTH)
                                                      : PTR_W'(entry_count);
  assign slot_ok = CW'(slot) < CW'(TABLE_DEPTH);

  assign sum_c = {1'b0, lo} + {1'b0, hi};
  assign mid_c = ADDR_W'(sum_c[PTR_W:1]);

  assign lt      = rd_data < key;
  assign lo_next = lt ? (PTR_W'(mid) + PTR_W'(1)) : lo;
  assign hi_next = lt ? hi : PTR_W'(mid);
  assign sum_n   = {1'b0, lo_next} + {1'b0, hi_next};
  assign mid_n   = ADDR_W'(sum_n[PTR_W:1]);

  // First probe comes from the registered bounds, later ones straight from the step.
  assign rd_addr = cmd.step ? mid_n : mid_c;

  assign status.range_ok = lo < hi;
  assign status.eq       = rd_data == key;
  assign status.next_ok  = lo_next < hi_next;

  skt_ram #(
    .WIDTH(KEY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (cmd.write & slot_ok),
    .waddr(ADDR_W'(slot)),
    .wdata(entry_key[KEY_W-1:0]),
    .re   (cmd.rd),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= search_key[KEY_W-1:0];
      lo  <= '0;
      hi  <= hmax;
      hit <= 1'b0;
    end
    if (cmd.step) begin
      lo <= lo_next;
      hi <= hi_next;
    end
    if (cmd.rd) begin
      mid <= rd_addr;
    end
    if (cmd.hit) begin
      hit     <= 1'b1;
      hit_key <= rd_data;
    end
    if (cmd.load_out) begin
      found       <= hit;
      match_index <= hit ? IX_W'(mid) : '0;
      match_key   <= hit ? KP_W'(hit_key) : '0;
    end
  end

endmodule

// ===== rtl/core/skt_ctrl.sv =====
// Sequencing FSM for writes, search probes and result hand-off.
module skt_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             req_type,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  skt_pkg::status_t status,
  output skt_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_PROBE  = 4'b0010,
    ST_CMP    = 4'b0100,
    ST_RESULT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (req_type == skt_pkg::REQ_SEARCH) begin
            cmd.start  = 1'b1;
            state_next = ST_PROBE;
          end else begin
            cmd.write = 1'b1;
          end
        end
      end
      ST_PROBE: begin
        if (status.range_ok) begin
          cmd.rd     = 1'b1;
          state_next = ST_CMP;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_CMP: begin
        if (status.eq) begin
          cmd.hit    = 1'b1;
          state_next = ST_RESULT;
        end else begin
          cmd.step = 1'b1;
          if (status.next_ok) begin
            cmd.rd = 1'b1;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign out_valid_next = cmd.load_out || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
